// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the knock tracker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pkt_pkg.sv
// ----------------------------------------------------------------------------
// pkt_pkg
// Types and constants shared by the port knock tracker modules.
// ----------------------------------------------------------------------------
package pkt_pkg;

  localparam int PORT_W        = 16;
  localparam int ADDR_W        = 32;
  localparam int PORTS_PER_SEQ = 3;
  localparam int CFG_IDX_W     = 2;

  typedef logic [PORT_W-1:0] port_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_APPEND  = 3'd1,
    ST_ERASED  = 3'd2,
    ST_GRANTED = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    UPD_NONE   = 2'd0,
    UPD_ALLOC  = 2'd1,
    UPD_APPEND = 2'd2,
    UPD_ERASE  = 2'd3
  } upd_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST  = 2'd0,
    CFG_SECOND = 2'd1,
    CFG_THIRD  = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  localparam port_t EXP_FIRST_RST  = 16'd5002;
  localparam port_t EXP_SECOND_RST = 16'd5003;
  localparam port_t EXP_THIRD_RST  = 16'd5001;

  localparam logic [1:0] SEQ_LEN = 2'd3;

  // search result for the address held in the input register
  typedef struct packed {
    logic       hit;
    logic       free_found;
    logic [1:0] count;
    port_t [PORTS_PER_SEQ-1:0] ports;
  } lookup_t;

  typedef struct packed {
    upd_op_t op;
    port_t   port;
  } update_t;

endpackage

// File: rtl/core/pkt_table.sv
// ----------------------------------------------------------------------------
// pkt_table
// Per-source entry store with parallel address search and one update a cycle.
// ----------------------------------------------------------------------------
module pkt_table import pkt_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  addr_t   lk_address,
  input  update_t upd,
  output lookup_t lk
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [ENTRIES-1:0] valid_r;
  addr_t              addr_r  [ENTRIES];
  logic [1:0]         count_r [ENTRIES];
  port_t              ports_r [ENTRIES][PORTS_PER_SEQ];

  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (addr_r[i] == lk_address);
    end
  end

  // lowest-numbered match and lowest-numbered free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    lk.hit        = |match;
    lk.free_found = ~&valid_r;
    lk.count      = count_r[hit_idx];
    for (int k = 0; k < PORTS_PER_SEQ; k++) begin
      lk.ports[k] = ports_r[hit_idx][k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      case (upd.op)
        UPD_ALLOC: valid_r[free_idx] <= 1'b1;
        UPD_ERASE: valid_r[hit_idx]  <= 1'b0;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (upd.op)
      UPD_ALLOC: begin
        addr_r[free_idx]     <= lk_address;
        count_r[free_idx]    <= 2'd1;
        ports_r[free_idx][0] <= upd.port;
      end
      UPD_APPEND: begin
        ports_r[hit_idx][count_r[hit_idx]] <= upd.port;
        count_r[hit_idx]                   <= count_r[hit_idx] + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/pkt_decide.sv
// ----------------------------------------------------------------------------
// pkt_decide
// Chooses the table update and the status for one knock from the search result.
// ----------------------------------------------------------------------------
module pkt_decide import pkt_pkg::*; (
  input  logic    item_valid,
  input  lookup_t lk,
  input  port_t   port,
  input  port_t   exp_first,
  input  port_t   exp_second,
  input  port_t   exp_third,
  output update_t upd,
  output status_t status
);

  logic seq_match;

  assign seq_match = (lk.ports[0] == exp_first) &&
                     (lk.ports[1] == exp_second) &&
                     (lk.ports[2] == exp_third);

  always_comb begin
    upd.port = port;
    upd.op   = UPD_NONE;
    if (!lk.hit) begin
      if (lk.free_found) begin
        status = ST_NEW;
        upd.op = UPD_ALLOC;
      end else begin
        status = ST_FULL;
      end
    end else if (lk.count != SEQ_LEN) begin
      status = ST_APPEND;
      upd.op = UPD_APPEND;
    end else if (seq_match) begin
      status = ST_GRANTED;
    end else begin
      status = ST_ERASED;
      upd.op = UPD_ERASE;
    end
    if (!item_valid) begin
      upd.op = UPD_NONE;
    end
  end

endmodule

// File: rtl/core/port_knock_sequence_tracker.sv
// ----------------------------------------------------------------------------
// port_knock_sequence_tracker
// Tracks knock sequences per IPv4 source and grants access on a full match.
// ----------------------------------------------------------------------------
//  channel  ports                                  handshake
//  input    in_src_address, in_knock_port          start && !busy
//  result   out_status, out_granted                out_strobe, one cycle
//  config   cfg_index, cfg_data                    cfg_valid && cfg_ready
//
//  one knock per cycle; the result strobes once start is taken and has passed
//  the input register, then the table search and the result register
//  busy stays low and cfg_ready stays high
//  synchronous reset empties the table and loads the default ports
//  the receiver cannot stall, so no result is ever held back
// ----------------------------------------------------------------------------
module port_knock_sequence_tracker import pkt_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_W-1:0]    in_src_address,
  input  logic [PORT_W-1:0]    in_knock_port,
  output logic                 out_strobe,
  output logic [2:0]           out_status,
  output logic                 out_granted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_data
);

`include "assert_macros.svh"

  logic    in_valid_r;
  addr_t   in_addr_r;
  port_t   in_port_r;
  port_t   exp_first_r;
  port_t   exp_second_r;
  port_t   exp_third_r;
  logic    out_strobe_r;
  status_t out_status_r;
  logic    out_granted_r;

  lookup_t lk;
  update_t upd;
  status_t status;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_addr_r <= in_src_address;
      in_port_r <= in_knock_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_first_r  <= EXP_FIRST_RST;
      exp_second_r <= EXP_SECOND_RST;
      exp_third_r  <= EXP_THIRD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST:  exp_first_r  <= cfg_data;
        CFG_SECOND: exp_second_r <= cfg_data;
        CFG_THIRD:  exp_third_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  pkt_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .lk_address (in_addr_r),
    .upd        (upd),
    .lk         (lk)
  );

  pkt_decide u_decide (
    .item_valid (in_valid_r),
    .lk         (lk),
    .port       (in_port_r),
    .exp_first  (exp_first_r),
    .exp_second (exp_second_r),
    .exp_third  (exp_third_r),
    .upd        (upd),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_status_r  <= status;
      out_granted_r <= (status == ST_GRANTED);
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

  `ASSERT_CLK(a_result_follows, start && !busy |=> ##1 out_strobe, "accepted knock gave no result")
  `ASSERT_CLK(a_grant_flag, out_strobe |-> (out_granted == (out_status == ST_GRANTED)), "grant flag disagrees with status")
  `ASSERT_CLK(a_full_status, in_valid_r && !lk.hit && !lk.free_found |=> out_status == ST_FULL, "full table not reported")
  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe && !in_valid_r, "pipeline not cleared by reset")

endmodule
